@@ src/text_console_cell_writer_core_macros.svh @@
// Assertion macros shared by the console RTL.
`ifndef TEXT_CONSOLE_CELL_WRITER_CORE_MACROS_SVH
`define TEXT_CONSOLE_CELL_WRITER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define TCCW_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("console assertion failed: same-cycle implication");
`define TCCW_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("console assertion failed: next-cycle implication");
`else
`define TCCW_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define TCCW_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

@@ src/tccw_pkg.sv @@
package tccw_pkg;

  localparam logic [7:0]  CH_BS      = 8'd8;
  localparam logic [7:0]  CH_TAB     = 8'd9;
  localparam logic [7:0]  CH_LF      = 8'd10;
  localparam logic [7:0]  CH_CR      = 8'd13;
  localparam logic [7:0]  BLANK_CH   = 8'h20;
  localparam logic [15:0] RESET_CELL = 16'h0720;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } tccw_op_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_PUT,
    WR_INIT,
    WR_BLANK,
    WR_SHIFT
  } tccw_wr_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_CELL,
    RD_SHIFT
  } tccw_rd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_CLEAR,
    ST_SC_RD,
    ST_SC_WR
  } tccw_state_t;

  typedef struct packed {
    logic     latch;
    logic     cur_put;
    logic     cur_home;
    tccw_wr_t wr;
    tccw_rd_t rd;
    logic     ptr_inc;
    logic     out_load;
    logic     out_scrolled;
  } tccw_ctl_t;

  typedef struct packed {
    tccw_op_t op;
    logic     put_scrolls;
    logic     ptr_last;
    logic     out_free;
  } tccw_stat_t;

endpackage

@@ src/tccw_ctrl.sv @@
`include "text_console_cell_writer_core_macros.svh"

module tccw_ctrl
  import tccw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  tccw_stat_t stat,
  output tccw_ctl_t  ctl
);

  tccw_state_t state_r;
  tccw_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    ctl              = '0;
    ctl.wr           = WR_NONE;
    ctl.rd           = RD_NONE;
    in_stall         = 1'b1;
    case (state_r)
      ST_INIT: begin
        ctl.wr      = WR_INIT;
        ctl.ptr_inc = 1'b1;
        if (stat.ptr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall  = 1'b0;
        ctl.latch = in_valid;
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.out_free) begin
          case (stat.op)
            OP_PUT: begin
              ctl.cur_put = 1'b1;
              ctl.wr      = WR_PUT;
              if (stat.put_scrolls) begin
                state_nxt = ST_SC_RD;
              end else begin
                ctl.out_load = 1'b1;
                state_nxt    = ST_IDLE;
              end
            end
            OP_CLEAR: begin
              ctl.cur_home = 1'b1;
              state_nxt    = ST_CLEAR;
            end
            OP_READ: begin
              ctl.rd    = RD_CELL;
              state_nxt = ST_READ;
            end
            default: begin
              ctl.out_load = 1'b1;
              state_nxt    = ST_IDLE;
            end
          endcase
        end
      end
      ST_READ: begin
        ctl.out_load = 1'b1;
        state_nxt    = ST_IDLE;
      end
      ST_CLEAR: begin
        ctl.wr      = WR_BLANK;
        ctl.ptr_inc = 1'b1;
        if (stat.ptr_last) begin
          ctl.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_SC_RD: begin
        ctl.rd    = RD_SHIFT;
        state_nxt = ST_SC_WR;
      end
      ST_SC_WR: begin
        ctl.wr      = WR_SHIFT;
        ctl.ptr_inc = 1'b1;
        if (stat.ptr_last) begin
          ctl.out_load     = 1'b1;
          ctl.out_scrolled = 1'b1;
          state_nxt        = ST_IDLE;
        end else begin
          state_nxt = ST_SC_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `TCCW_ASSERT_IMPL(a_load_when_free, clk, rst_n, ctl.out_load, stat.out_free)
  `TCCW_ASSERT_NEXT(a_shift_loops, clk, rst_n, (state_r == ST_SC_WR) && !stat.ptr_last, state_r == ST_SC_RD)
  `TCCW_ASSERT_IMPL(a_put_only_for_put, clk, rst_n, ctl.cur_put, stat.op == OP_PUT)

endmodule

@@ src/tccw_dpath.sv @@
`include "text_console_cell_writer_core_macros.svh"

module tccw_dpath
  import tccw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_char_code,
  input  logic [7:0]  in_attribute,
  input  logic [10:0] in_cell_index,
  input  tccw_ctl_t   ctl,
  output tccw_stat_t  stat,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_cursor_col,
  output logic [4:0]  out_cursor_row,
  output logic [10:0] out_cursor_offset,
  output logic        out_scrolled,
  output logic [15:0] out_cell_data
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int COPY  = (ROWS - 1) * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);

  tccw_op_t          op_r;
  logic [7:0]        ch_r;
  logic [7:0]        attr_r;
  logic [10:0]       idx_r;

  logic [CW-1:0]     col_r,  col_nxt;
  logic [RW-1:0]     line_r, line_nxt;
  logic [AW-1:0]     base_r, base_nxt;
  logic [AW-1:0]     ptr_r;

  logic              out_valid_r;
  logic [6:0]        out_col_r;
  logic [4:0]        out_row_r;
  logic [10:0]       out_off_r;
  logic              out_sc_r;
  logic [15:0]       out_data_r;

  logic [15:0]       mem [CELLS];
  logic [15:0]       rd_q_r;

  logic [CW:0]       p_col;
  logic [RW:0]       p_line;
  logic [AW:0]       p_base;
  logic              p_scroll;
  logic              p_we;
  logic [AW-1:0]     p_addr;
  logic [15:0]       p_data;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [15:0]       wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [AW:0]       src_addr;
  logic [AW:0]       off_sum;
  logic              idx_ok;
  logic              copy_zone;
  logic              out_free;
  logic [15:0]       blank;

  assign blank     = {attr_r, BLANK_CH};
  assign idx_ok    = (32'(idx_r) < CELLS);
  assign copy_zone = (32'(ptr_r) < COPY);
  assign src_addr  = {1'b0, ptr_r} + (AW + 1)'(COLUMNS);
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    p_col    = {1'b0, col_r};
    p_line   = {1'b0, line_r};
    p_base   = {1'b0, base_r};
    p_scroll = 1'b0;
    p_we     = 1'b0;
    p_addr   = base_r + AW'(col_r);
    p_data   = {attr_r, ch_r};
    case (ch_r)
      CH_LF: begin
        p_col  = '0;
        p_line = p_line + 1'b1;
        p_base = p_base + (AW + 1)'(COLUMNS);
      end
      CH_CR: begin
        p_col = '0;
      end
      CH_TAB: begin
        p_col = (p_col + (CW + 1)'(4)) & ~((CW + 1)'(3));
      end
      CH_BS: begin
        if (col_r != '0) begin
          p_col  = p_col - 1'b1;
          p_we   = 1'b1;
          p_addr = base_r + AW'(col_r) - 1'b1;
          p_data = blank;
        end
      end
      default: begin
        p_we  = 1'b1;
        p_col = p_col + 1'b1;
      end
    endcase
    if (p_col >= (CW + 1)'(COLUMNS)) begin
      p_col  = '0;
      p_line = p_line + 1'b1;
      p_base = p_base + (AW + 1)'(COLUMNS);
    end
    if (p_line >= (RW + 1)'(ROWS)) begin
      p_scroll = 1'b1;
      p_line   = (RW + 1)'(ROWS - 1);
      p_base   = (AW + 1)'(COPY);
    end
  end

  always_comb begin
    col_nxt  = col_r;
    line_nxt = line_r;
    base_nxt = base_r;
    if (ctl.cur_home) begin
      col_nxt  = '0;
      line_nxt = '0;
      base_nxt = '0;
    end else if (ctl.cur_put) begin
      col_nxt  = CW'(p_col);
      line_nxt = RW'(p_line);
      base_nxt = AW'(p_base);
    end
  end

  assign off_sum = {1'b0, base_nxt} + (AW + 1)'(col_nxt);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr_r;
    wr_data = blank;
    case (ctl.wr)
      WR_PUT: begin
        wr_en   = p_we;
        wr_addr = p_addr;
        wr_data = p_data;
      end
      WR_INIT: begin
        wr_en   = 1'b1;
        wr_data = RESET_CELL;
      end
      WR_BLANK: begin
        wr_en = 1'b1;
      end
      WR_SHIFT: begin
        wr_en   = 1'b1;
        wr_data = copy_zone ? rd_q_r : blank;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = AW'(idx_r);
    case (ctl.rd)
      RD_CELL: begin
        rd_en = idx_ok;
      end
      RD_SHIFT: begin
        rd_en   = copy_zone;
        rd_addr = AW'(src_addr);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      op_r   <= tccw_op_t'(in_cmd);
      ch_r   <= in_char_code;
      attr_r <= in_attribute;
      idx_r  <= in_cell_index;
    end
    if (ctl.out_load) begin
      out_col_r  <= 7'(col_nxt);
      out_row_r  <= 5'(line_nxt);
      out_off_r  <= 11'(off_sum);
      out_sc_r   <= ctl.out_scrolled;
      out_data_r <= (op_r == OP_READ && idx_ok) ? rd_q_r : 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      line_r      <= '0;
      base_r      <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      line_r <= line_nxt;
      base_r <= base_nxt;
      if (ctl.ptr_inc) begin
        ptr_r <= (ptr_r == AW'(CELLS - 1)) ? '0 : ptr_r + 1'b1;
      end
      if (ctl.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    stat             = '0;
    stat.op          = op_r;
    stat.put_scrolls = p_scroll;
    stat.ptr_last    = (ptr_r == AW'(CELLS - 1));
    stat.out_free    = out_free;
  end

  assign out_valid         = out_valid_r;
  assign out_cursor_col    = out_col_r;
  assign out_cursor_row    = out_row_r;
  assign out_cursor_offset = out_off_r;
  assign out_scrolled      = out_sc_r;
  assign out_cell_data     = out_data_r;

  `TCCW_ASSERT_IMPL(a_col_range, clk, rst_n, 1'b1, 32'(col_r) < COLUMNS)
  `TCCW_ASSERT_IMPL(a_base_tracks_line, clk, rst_n, 1'b1, 32'(base_r) == 32'(line_r) * COLUMNS)
  `TCCW_ASSERT_IMPL(a_write_in_range, clk, rst_n, wr_en, 32'(wr_addr) < CELLS)

endmodule

@@ src/text_console_cell_writer_core.sv @@
// Channel  Handshake           Payload
// in       in_valid/in_stall   in_cmd, in_char_code, in_attribute, in_cell_index
// out      out_valid/out_stall out_cursor_col, out_cursor_row, out_cursor_offset,
//                              out_scrolled, out_cell_data
//
// A put that does not scroll writes its cell through the single cell store write port.
// A read goes through the registered read port of the store before its result is loaded.
// A clear blanks every cell of the screen, one blank write per cycle.
// A scroll then rewrites every cell, copying each from the row below and blanking the last row.
// After reset the store is filled with grey blanks while in_stall is high.
// A transfer waits in the output register while out_stall is high; the next command is held.
module text_console_cell_writer_core
  import tccw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_char_code,
  input  logic [7:0]  in_attribute,
  input  logic [10:0] in_cell_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_cursor_col,
  output logic [4:0]  out_cursor_row,
  output logic [10:0] out_cursor_offset,
  output logic        out_scrolled,
  output logic [15:0] out_cell_data
);

  tccw_ctl_t  ctl;
  tccw_stat_t stat;

  tccw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  tccw_dpath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_cmd            (in_cmd),
    .in_char_code      (in_char_code),
    .in_attribute      (in_attribute),
    .in_cell_index     (in_cell_index),
    .ctl               (ctl),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cursor_col    (out_cursor_col),
    .out_cursor_row    (out_cursor_row),
    .out_cursor_offset (out_cursor_offset),
    .out_scrolled      (out_scrolled),
    .out_cell_data     (out_cell_data)
  );

endmodule
